[sv/mrc_pkg.sv]
`default_nettype none

package mrc_pkg;

  // frame bytes
  localparam logic [7:0] START_BYTE      = 8'h68;
  localparam logic [7:0] END_BYTE        = 8'h16;
  localparam logic [7:0] DATA_OFFSET     = 8'h33;
  localparam logic [7:0] CTRL_MASK       = 8'hDF;
  localparam logic [7:0] CTRL_READ_REPLY = 8'h81;
  localparam logic [7:0] CTRL_ABNORMAL   = 8'hC0;
  localparam logic [7:0] CTRL_NO_SUPPORT = 8'h40;

  // frame positions, counted from the first start byte
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_ADDR_FIRST = 9'd1;
  localparam logic [POS_W-1:0] POS_ADDR_LAST  = 9'd6;
  localparam logic [POS_W-1:0] POS_START2     = 9'd7;
  localparam logic [POS_W-1:0] POS_CTRL       = 9'd8;
  localparam logic [POS_W-1:0] POS_LEN        = 9'd9;
  localparam logic [POS_W-1:0] POS_ITEM_LO    = 9'd10;
  localparam logic [POS_W-1:0] POS_ITEM_HI    = 9'd11;
  localparam logic [POS_W-1:0] POS_DATA_FIRST = 9'd12;
  localparam logic [POS_W-1:0] POS_MAX        = 9'd511;
  localparam logic [POS_W-1:0] SUM_OFFSET     = 9'd10;
  localparam logic [POS_W-1:0] END_OFFSET     = 9'd11;

  // register map
  localparam int unsigned ADDR_W = 4;
  localparam logic REG_IDX_METER = 1'b0;
  localparam logic REG_IDX_ITEM  = 1'b1;

  // result queue
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_START       = 4'd2,
    ST_ADDRESS     = 4'd3,
    ST_OVERRUN     = 4'd4,
    ST_SUM         = 4'd5,
    ST_END         = 4'd6,
    ST_CONTROL     = 4'd7,
    ST_UNSUPPORTED = 4'd8,
    ST_ITEM        = 4'd9,
    ST_TINY        = 4'd10
  } status_t;

  // one queued result: value is the data byte or the data length
  typedef struct packed {
    logic       is_status;
    logic [7:0] value;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

[sv/meter_read_reply_checker.sv]
// a byte's results pass the input register and the result queue before they reach the output
// throughput: one byte per cycle while in_ready is high; the final byte of a buffer adds a status result
// an input register feeds combinational checking logic into an eight-entry result queue
// input stalls only while the queue could not take two more results after the held byte
// rst_n is synchronous, active low: clears the frame state, queue and both registers
`default_nettype none

module meter_read_reply_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_rx_byte,
  input  wire logic                       in_last_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_is_status,
  output logic [7:0]                      out_data_byte,
  output mrc_pkg::status_t                out_status,
  output logic [7:0]                      out_data_length,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);
  import mrc_pkg::*;

  // configuration
  logic [47:0] meter_address_r;
  logic [15:0] expected_item_r;
  logic        cfg_wr;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // frame state
  logic             hunting_r, hunting_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic [7:0]       declared_length_r, declared_length_nxt;
  logic [7:0]       control_code_r, control_code_nxt;
  logic [7:0]       item_low_r, item_low_nxt;
  logic             start_bad_r, start_bad_nxt;
  logic             address_bad_r, address_bad_nxt;
  logic             frame_complete_r, frame_complete_nxt;
  status_t          frame_outcome_r, frame_outcome_nxt;
  logic             sum_bad_r, sum_bad_nxt;
  logic             item_bad_r, item_bad_nxt;

  // checking logic
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] dl;
  logic [7:0]       want;
  logic [15:0]      item_id;
  logic             has_data;
  logic [7:0]       data_val;
  status_t          tail;
  status_t          fin_status;
  logic [7:0]       fin_length;
  result_t          first_res, second_res;
  logic [1:0]       push_n;

  // result queue
  result_t             rq_mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CNT_W-1:0] count_r;
  logic [RQ_PTR_W-1:0] wr_ptr_p1;
  logic                pop;
  logic [RQ_CNT_W-1:0] need;
  result_t             head;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meter_address_r <= '0;
      expected_item_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_IDX_METER: meter_address_r <= pwdata[47:0];
        REG_IDX_ITEM:  expected_item_r <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_IDX_METER: prdata = {16'd0, meter_address_r};
      REG_IDX_ITEM:  prdata = {48'd0, expected_item_r};
    endcase
  end

  // queue room: the held byte may still push two results
  assign need     = s1_valid_r ? (s1_last_r ? RQ_CNT_W'(2) : RQ_CNT_W'(1)) : '0;
  assign in_ready = (count_r + need) <= RQ_CNT_W'(RQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid & in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_comb begin
    case (p[2:0])
      3'd1:    want = meter_address_r[7:0];
      3'd2:    want = meter_address_r[15:8];
      3'd3:    want = meter_address_r[23:16];
      3'd4:    want = meter_address_r[31:24];
      3'd5:    want = meter_address_r[39:32];
      3'd6:    want = meter_address_r[47:40];
      default: want = 8'd0;
    endcase
  end

  assign item_id = {s1_byte_r - DATA_OFFSET, item_low_r - DATA_OFFSET};

  always_comb begin
    hunting_nxt         = hunting_r;
    position_nxt        = position_r;
    running_sum_nxt     = running_sum_r;
    declared_length_nxt = declared_length_r;
    control_code_nxt    = control_code_r;
    item_low_nxt        = item_low_r;
    start_bad_nxt       = start_bad_r;
    address_bad_nxt     = address_bad_r;
    frame_complete_nxt  = frame_complete_r;
    frame_outcome_nxt   = frame_outcome_r;
    sum_bad_nxt         = sum_bad_r;
    item_bad_nxt        = item_bad_r;
    p                   = position_r + POS_W'(position_r != POS_MAX);
    dl                  = {1'b0, declared_length_r};
    has_data            = 1'b0;
    data_val            = 8'd0;
    tail                = ST_OK;
    fin_status          = ST_OK;
    fin_length          = 8'd0;

    if (s1_valid_r) begin
      if (hunting_r) begin
        if (s1_byte_r == START_BYTE) begin
          hunting_nxt     = 1'b0;
          position_nxt    = '0;
          running_sum_nxt = s1_byte_r;
        end
      end else if (!frame_complete_r) begin
        position_nxt = p;
        if (p >= POS_ADDR_FIRST && p <= POS_ADDR_LAST) begin
          if (want != s1_byte_r) address_bad_nxt = 1'b1;
        end else if (p == POS_START2) begin
          start_bad_nxt = (s1_byte_r != START_BYTE);
        end else if (p == POS_CTRL) begin
          control_code_nxt = s1_byte_r;
        end else if (p == POS_LEN) begin
          declared_length_nxt = s1_byte_r;
          dl = {1'b0, s1_byte_r};
        end else if (p == POS_ITEM_LO) begin
          item_low_nxt = s1_byte_r;
        end else if (p == POS_ITEM_HI) begin
          item_bad_nxt = (item_id != expected_item_r);
        end

        // tail check order: sum, end byte, control code, item, length
        if (sum_bad_nxt) tail = ST_SUM;
        else if (s1_byte_r != END_BYTE) tail = ST_END;
        else if (control_code_nxt == CTRL_ABNORMAL) tail = ST_CONTROL;
        else if ((control_code_nxt & CTRL_NO_SUPPORT) != 8'd0) tail = ST_UNSUPPORTED;
        else if ((control_code_nxt & CTRL_MASK) != CTRL_READ_REPLY) tail = ST_CONTROL;
        else if (item_bad_nxt) tail = ST_ITEM;
        else if (declared_length_nxt < 8'd2) tail = ST_TINY;
        else tail = ST_OK;

        if (p < POS_ITEM_LO || p < dl + SUM_OFFSET) begin
          running_sum_nxt = running_sum_r + s1_byte_r;
          if (p >= POS_DATA_FIRST) begin
            has_data = 1'b1;
            data_val = s1_byte_r - DATA_OFFSET;
          end
        end else if (p == dl + SUM_OFFSET) begin
          sum_bad_nxt = (running_sum_r != s1_byte_r);
        end else if (p == dl + END_OFFSET) begin
          frame_complete_nxt = 1'b1;
          frame_outcome_nxt  = tail;
        end
      end

      if (s1_last_r) begin
        if (hunting_nxt || position_nxt < POS_DATA_FIRST) fin_status = ST_SHORT;
        else if (start_bad_nxt) fin_status = ST_START;
        else if (address_bad_nxt) fin_status = ST_ADDRESS;
        else if (!frame_complete_nxt) fin_status = ST_OVERRUN;
        else fin_status = frame_outcome_nxt;
        if (fin_status == ST_OK) fin_length = declared_length_nxt - 8'd2;

        // back to hunting for the next buffer
        hunting_nxt         = 1'b1;
        position_nxt        = '0;
        running_sum_nxt     = 8'd0;
        declared_length_nxt = 8'd0;
        control_code_nxt    = 8'd0;
        item_low_nxt        = 8'd0;
        start_bad_nxt       = 1'b0;
        address_bad_nxt     = 1'b0;
        frame_complete_nxt  = 1'b0;
        frame_outcome_nxt   = ST_OK;
        sum_bad_nxt         = 1'b0;
        item_bad_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r         <= 1'b1;
      position_r        <= '0;
      running_sum_r     <= 8'd0;
      declared_length_r <= 8'd0;
      control_code_r    <= 8'd0;
      item_low_r        <= 8'd0;
      start_bad_r       <= 1'b0;
      address_bad_r     <= 1'b0;
      frame_complete_r  <= 1'b0;
      frame_outcome_r   <= ST_OK;
      sum_bad_r         <= 1'b0;
      item_bad_r        <= 1'b0;
    end else begin
      hunting_r         <= hunting_nxt;
      position_r        <= position_nxt;
      running_sum_r     <= running_sum_nxt;
      declared_length_r <= declared_length_nxt;
      control_code_r    <= control_code_nxt;
      item_low_r        <= item_low_nxt;
      start_bad_r       <= start_bad_nxt;
      address_bad_r     <= address_bad_nxt;
      frame_complete_r  <= frame_complete_nxt;
      frame_outcome_r   <= frame_outcome_nxt;
      sum_bad_r         <= sum_bad_nxt;
      item_bad_r        <= item_bad_nxt;
    end
  end

  // data result goes ahead of the status result
  assign first_res  = has_data ? result_t'{is_status: 1'b0, value: data_val, status: ST_OK}
                               : result_t'{is_status: 1'b1, value: fin_length,
                                           status: fin_status};
  assign second_res = result_t'{is_status: 1'b1, value: fin_length, status: fin_status};
  assign push_n     = s1_valid_r ? (2'(has_data) + 2'(s1_last_r)) : 2'd0;

  assign wr_ptr_p1 = wr_ptr_r + RQ_PTR_W'(1);
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) rq_mem_r[wr_ptr_r] <= first_res;
    if (push_n == 2'd2) rq_mem_r[wr_ptr_p1] <= second_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_PTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + RQ_PTR_W'(1);
      count_r <= count_r + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
    end
  end

  assign head            = rq_mem_r[rd_ptr_r];
  assign out_valid       = (count_r != '0);
  assign out_is_status   = head.is_status;
  assign out_last        = head.is_status;
  assign out_data_byte   = head.is_status ? 8'd0 : head.value;
  assign out_data_length = head.is_status ? head.value : 8'd0;
  assign out_status      = head.is_status ? head.status : ST_OK;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_hunt_position: assert property (@(posedge clk) disable iff (!rst_n)
    hunting_r |-> position_r == '0)
    else $error("position moved while hunting");

  a_status_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |=> hunting_r && !frame_complete_r)
    else $error("frame state not cleared after status");

  a_complete_framed: assert property (@(posedge clk) disable iff (!rst_n)
    frame_complete_r |-> !hunting_r && position_r >= POS_ITEM_HI)
    else $error("frame complete without a framed run");
`endif

endmodule

`default_nettype wire

[test/tb_meter_read_reply_checker.sv]
`timescale 1ns / 100ps

module tb_meter_read_reply_checker;
  import mrc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 480;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_SHOWN    = 10;
  localparam int MIN_LEN      = 2;

  typedef struct {
    logic [7:0] value;
    logic       fin;
  } rx_byte_t;

  typedef struct {
    logic       is_status;
    logic [7:0] data_byte;
    status_t    status;
    logic [7:0] data_length;
    logic       last;
  } reply_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_is_status;
  logic [7:0]        out_data_byte;
  status_t           out_status;
  logic [7:0]        out_data_length;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  meter_read_reply_checker DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_status(out_is_status), .out_data_byte(out_data_byte),
    .out_status(out_status), .out_data_length(out_data_length), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // stimulus and scoreboard storage
  rx_byte_t   rx_bytes_q[$];
  reply_t     replies_due[$];
  logic [7:0] frame_buf[$];
  logic [7:0] frame_sum;
  int         bytes_sent = 0;
  int         bytes_taken = 0;
  int         phase_bytes = 0;
  int         errors = 0;
  int         cycle_count = 0;
  int         hold_asked = 0;

  // register copies
  logic [47:0] cfg_meter = '0;
  logic [15:0] cfg_item = '0;

  // frame tracking state
  logic        seeking = 1'b1;
  int          frame_pos = 0;
  logic [7:0]  byte_sum = '0;
  logic [7:0]  len_field = '0;
  logic [7:0]  ctrl_field = '0;
  logic [7:0]  item_lo_field = '0;
  logic        start_err = 1'b0;
  logic        addr_err = 1'b0;
  logic        tail_seen = 1'b0;
  status_t     tail_status = ST_OK;
  logic        sum_err = 1'b0;
  logic        item_err = 1'b0;

  task automatic frame_clear();
    seeking = 1'b1;
    frame_pos = 0;
    byte_sum = '0;
    len_field = '0;
    ctrl_field = '0;
    item_lo_field = '0;
    start_err = 1'b0;
    addr_err = 1'b0;
    tail_seen = 1'b0;
    tail_status = ST_OK;
    sum_err = 1'b0;
    item_err = 1'b0;
  endtask

  function automatic status_t judge_tail(input logic [7:0] end_b);
    if (sum_err) return ST_SUM;
    if (end_b != END_BYTE) return ST_END;
    if (ctrl_field == CTRL_ABNORMAL) return ST_CONTROL;
    if ((ctrl_field & CTRL_NO_SUPPORT) != 0) return ST_UNSUPPORTED;
    if ((ctrl_field & CTRL_MASK) != CTRL_READ_REPLY) return ST_CONTROL;
    if (item_err) return ST_ITEM;
    if (len_field < MIN_LEN) return ST_TINY;
    return ST_OK;
  endfunction

  task automatic push_reply(input logic is_st, input logic [7:0] db, input status_t st,
                            input logic [7:0] dl);
    reply_t r;
    r.is_status = is_st;
    r.data_byte = db;
    r.status = st;
    r.data_length = dl;
    r.last = is_st;
    replies_due.push_back(r);
  endtask

  // works out the replies that one received byte causes
  task automatic track_rx_byte(input logic [7:0] b, input logic fin);
    int         p;
    int         dl;
    logic [7:0] hi;
    logic [7:0] lo;
    status_t    st;
    if (seeking) begin
      if (b == START_BYTE) begin
        seeking = 1'b0;
        frame_pos = 0;
        byte_sum = b;
      end
    end else if (!tail_seen) begin
      if (frame_pos < POS_MAX) frame_pos++;
      p = frame_pos;
      dl = len_field;
      if (p >= POS_ADDR_FIRST && p <= POS_ADDR_LAST) begin
        if (cfg_meter[8*(p-1) +: 8] != b) addr_err = 1'b1;
      end else if (p == POS_START2) begin
        start_err = (b != START_BYTE);
      end else if (p == POS_CTRL) begin
        ctrl_field = b;
      end else if (p == POS_LEN) begin
        len_field = b;
        dl = b;
      end else if (p == POS_ITEM_LO) begin
        item_lo_field = b;
      end else if (p == POS_ITEM_HI) begin
        hi = b - DATA_OFFSET;
        lo = item_lo_field - DATA_OFFSET;
        item_err = ({hi, lo} != cfg_item);
      end
      if (p < SUM_OFFSET || p < dl + SUM_OFFSET) begin
        byte_sum = byte_sum + b;
        if (p >= POS_DATA_FIRST) push_reply(1'b0, b - DATA_OFFSET, ST_OK, 8'd0);
      end else if (p == dl + SUM_OFFSET) begin
        sum_err = (byte_sum != b);
      end else if (p == dl + END_OFFSET) begin
        tail_seen = 1'b1;
        tail_status = judge_tail(b);
      end
    end
    if (fin) begin
      if (seeking || frame_pos < POS_DATA_FIRST) st = ST_SHORT;
      else if (start_err) st = ST_START;
      else if (addr_err) st = ST_ADDRESS;
      else if (!tail_seen) st = ST_OVERRUN;
      else st = tail_status;
      push_reply(1'b1, 8'd0, st, (st == ST_OK) ? len_field - 8'(MIN_LEN) : 8'd0);
      frame_clear();
    end
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_rx
    rx_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        nxt = rx_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_rx_byte <= nxt.value;
        in_last_byte <= nxt.fin;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode now and then, plus requested long hold-offs
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_taken = 0;

  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_taken + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // transfer monitor: predict on accepted bytes, then check the reply side
  always @(posedge clk) begin : watch_replies
    reply_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_rx_byte(in_rx_byte, in_last_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("unexpected reply: st=%0d byte=%02h status=%0d len=%0d last=%0d",
                     out_is_status, out_data_byte, out_status, out_data_length, out_last);
        end else begin
          want = replies_due.pop_front();
          if (out_is_status !== want.is_status || out_data_byte !== want.data_byte ||
              out_status !== want.status || out_data_length !== want.data_length ||
              out_last !== want.last) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $write("reply mismatch: expected st=%0d byte=%02h status=%0d len=%0d last=%0d, ",
                     want.is_status, want.data_byte, want.status, want.data_length,
                     want.last);
              $display("got st=%0d byte=%02h status=%0d len=%0d last=%0d",
                       out_is_status, out_data_byte, out_status, out_data_length,
                       out_last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("meter_read_reply_checker test failed");
      $finish;
    end
  end

  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    return (v >= avoid) ? v + 8'd1 : v;
  endfunction

  task automatic cfg_write(input logic idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IDX_METER) cfg_meter = value[47:0];
    else cfg_item = value[15:0];
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_sent || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_summed(input logic [7:0] v);
    frame_buf.push_back(v);
    frame_sum = frame_sum + v;
  endtask

  // appends one frame; for lengths under two the item bytes overlap the sum byte and, for length zero, the end byte
  task automatic add_frame(input logic [47:0] addr, input logic [15:0] item,
                           input logic [7:0] ctrl, input logic [7:0] len,
                           input bit bad_start, input bit bad_sum, input bit bad_end);
    int k;
    frame_sum = '0;
    put_summed(START_BYTE);
    for (k = 0; k < 6; k++) put_summed(addr[8*k +: 8]);
    put_summed(bad_start ? other_than(START_BYTE) : START_BYTE);
    put_summed(ctrl);
    put_summed(len);
    for (k = 0; k < len; k++) begin
      if (k == 0) put_summed(item[7:0] + DATA_OFFSET);
      else if (k == 1) put_summed(item[15:8] + DATA_OFFSET);
      else put_summed(8'($urandom_range(0, 255)));
    end
    frame_buf.push_back(bad_sum ? frame_sum ^ 8'($urandom_range(1, 255)) : frame_sum);
    frame_buf.push_back(bad_end ? other_than(END_BYTE) : END_BYTE);
  endtask

  task automatic cut_buffer(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic add_trailer(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic post_buffer();
    rx_byte_t item;
    int       k;
    for (k = 0; k < frame_buf.size(); k++) begin
      item.value = frame_buf[k];
      item.fin = (k == frame_buf.size() - 1);
      rx_bytes_q.push_back(item);
      bytes_sent++;
    end
    phase_bytes += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic random_buffer();
    int          kind;
    int          r;
    int          k;
    logic [47:0] addr;
    logic [15:0] item;
    logic [7:0]  ctrl;
    logic [7:0]  len;
    bit          bad_start;
    bit          bad_sum;
    bit          bad_end;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      add_trailer($urandom_range(1, 16));
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) frame_buf.push_back(other_than(START_BYTE));
      addr = cfg_meter;
      item = cfg_item;
      ctrl = $urandom_range(0, 1) ? CTRL_READ_REPLY : (CTRL_READ_REPLY | ~CTRL_MASK);
      r = $urandom_range(0, 99);
      if (r < 2) len = 8'($urandom_range(11, 255));
      else if (r < 8) len = 8'($urandom_range(0, 1));
      else len = 8'($urandom_range(2, 10));
      bad_start = 0;
      bad_sum = 0;
      bad_end = 0;
      if (kind >= 60) begin
        case ($urandom_range(0, 6))
          0: begin
            k = $urandom_range(0, 5);
            addr[8*k +: 8] = addr[8*k +: 8] ^ 8'($urandom_range(1, 255));
          end
          1: bad_start = 1;
          2: bad_sum = 1;
          3: bad_end = 1;
          4: ctrl = 8'($urandom_range(0, 255));
          5: ctrl = $urandom_range(0, 1) ? CTRL_ABNORMAL : (ctrl | CTRL_NO_SUPPORT);
          default: item = item ^ 16'($urandom_range(1, 65535));
        endcase
      end
      add_frame(addr, item, ctrl, len, bad_start, bad_sum, bad_end);
      if ($urandom_range(0, 9) == 0) cut_buffer($urandom_range(1, frame_buf.size() - 1));
      else if ($urandom_range(0, 3) == 0) add_trailer($urandom_range(1, 3));
    end
    post_buffer();
  endtask

  initial begin : stimulus
    int          ph;
    int          n;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [63:0] meter_val;
    logic [63:0] item_val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_IDX_METER, 64'h0000_A1B2_C3D4_E5F6);
    cfg_write(REG_IDX_ITEM, 64'h0000_0000_0000_9010);

    // good replies, one with leading noise, alternate control bit and trailing bytes
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd2, 0, 0, 0);
    post_buffer();
    frame_buf.push_back(8'hFE);
    frame_buf.push_back(8'h00);
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY | ~CTRL_MASK, 8'd6, 0, 0, 0);
    add_trailer(2);
    post_buffer();
    // no start byte at all, and a start byte that is the last byte
    frame_buf.push_back(8'h00);
    post_buffer();
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(START_BYTE);
    post_buffer();
    // too few bytes after the start byte, then a bad second start byte and a wrong address
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd4, 0, 0, 0);
    cut_buffer(POS_DATA_FIRST);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd4, 1, 0, 0);
    post_buffer();
    add_frame(cfg_meter ^ 48'h0100_0000_0000, cfg_item, CTRL_READ_REPLY, 8'd4, 0, 0, 0);
    post_buffer();
    // overrun: end byte missing, and buffer ending inside the data
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd4, 0, 0, 0);
    cut_buffer(frame_buf.size() - 1);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd6, 0, 0, 0);
    cut_buffer(POS_DATA_FIRST + 2);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd3, 0, 1, 0);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd3, 0, 0, 1);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_ABNORMAL, 8'd2, 0, 0, 0);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY | CTRL_NO_SUPPORT, 8'd2, 0, 0, 0);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY & ~CTRL_ABNORMAL & 8'h7F, 8'd2, 0, 0, 0);
    post_buffer();
    add_frame(cfg_meter, cfg_item ^ 16'h8000, CTRL_READ_REPLY, 8'd2, 0, 0, 0);
    post_buffer();
    add_frame(cfg_meter, cfg_item, CTRL_READ_REPLY, 8'd255, 0, 0, 0);
    post_buffer();
    wait_idle();

    // tiny lengths: item id comes partly or wholly from the sum and end bytes
    for (n = 0; n < MIN_LEN; n++) begin
      add_frame(cfg_meter, 16'h0042, CTRL_READ_REPLY, 8'(n), 0, 0, 0);
      lo = frame_buf[POS_ITEM_LO] - DATA_OFFSET;
      hi = frame_buf[POS_ITEM_HI] - DATA_OFFSET;
      cfg_write(REG_IDX_ITEM, {48'd0, hi, lo});
      post_buffer();
      wait_idle();
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          meter_val = '0;
          item_val = '0;
        end
        1: begin
          meter_val = '1;
          item_val = '1;
        end
        default: begin
          meter_val = {$urandom, $urandom};
          item_val = {$urandom, $urandom};
        end
      endcase
      cfg_write(REG_IDX_METER, meter_val);
      cfg_write(REG_IDX_ITEM, item_val);
      phase_bytes = 0;
      while (phase_bytes < RANDOM_BYTES / PHASES) random_buffer();
      // receiver holds off while the whole phase is being offered
      if (ph == 2 || ph == 5) hold_asked++;
      wait_idle();
    end

    if (errors == 0) begin
      $display("meter_read_reply_checker test passed");
    end else begin
      $display("meter_read_reply_checker test failed");
    end
    $finish;
  end

endmodule
